// ===== sv/fdmd_pkg.sv =====
// fdmd_pkg: shared widths and constants of the frame difference motion detector.
// No dependencies; imported by fdmd_isqrt, the top level and fdmd_checker.
`timescale 1ns / 1ps

package fdmd_pkg;

  // Frame store geometry
  localparam int MAX_PIXELS = 262144;
  localparam int ADDR_W     = (MAX_PIXELS > 1) ? $clog2(MAX_PIXELS) : 1;
  localparam int IDX_W      = $clog2(MAX_PIXELS + 1);
  localparam int PIX_W      = 24;
  localparam int CH_W       = 8;

  // Port field widths
  localparam int THR_W      = 11;
  localparam int SUM_W      = 33;
  localparam int CNT_W      = 19;
  localparam logic [THR_W-1:0] THR_RESET = THR_W'(40);

  // Distance datapath: weighted channel diff, squares, radicand, root
  localparam int WD_W       = 10;
  localparam int SQ_W       = 2 * WD_W;
  localparam int SQ_SUM_W   = SQ_W + 1;
  localparam int RAD_W      = 30;
  localparam int ROOT_W     = RAD_W / 2;
  localparam int REM_W      = ROOT_W + 4;
  localparam int ITER_W     = $clog2(ROOT_W);

  // Motion compare: threshold * count, scaled by 16
  localparam int PROD_W     = THR_W + IDX_W;
  localparam int CMP_W      = (PROD_W + 4 > SUM_W) ? PROD_W + 4 : SUM_W + 1;
  localparam logic [SUM_W-1:0] SUM_MAX = {SUM_W{1'b1}};

  // Sequencer states
  typedef enum logic [7:0] {
    S_IDLE   = 8'b0000_0001,
    S_DIFF   = 8'b0000_0010,
    S_SUMSQ  = 8'b0000_0100,
    S_ROOT   = 8'b0000_1000,
    S_ACC    = 8'b0001_0000,
    S_CLOSE  = 8'b0010_0000,
    S_MUL    = 8'b0100_0000,
    S_REPORT = 8'b1000_0000
  } state_t;

  // Handshake between sequencer and root unit
  typedef struct packed {
    logic             start;
    logic [RAD_W-1:0] radicand;
  } root_req_t;

  typedef struct packed {
    logic              done;
    logic [ROOT_W-1:0] root;
  } root_rsp_t;

endpackage

// ===== sv/fdmd_ram.sv =====
// fdmd_ram: generic single-write, single-read synchronous RAM, registered read.
// No dependencies.
`timescale 1ns / 1ps

module fdmd_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                                   clk,
  input  logic                                   we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                       wdata,
  input  logic                                   re,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                       rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Read port, registered
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== sv/fdmd_isqrt.sv =====
// fdmd_isqrt: iterative integer square root, one result bit per cycle.
// Depends on fdmd_pkg (widths, request/response structs).
`timescale 1ns / 1ps

module fdmd_isqrt
  import fdmd_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  root_req_t req,
  output root_rsp_t rsp
);

  logic [RAD_W-1:0]  rad;
  logic [REM_W-1:0]  rem;
  logic [ROOT_W-1:0] root;
  logic [ITER_W-1:0] cnt;
  logic              busy;
  logic              done;

  logic [REM_W-1:0]  rem_sh;
  logic [REM_W-1:0]  trial;
  logic              take;

  // One digit step: bring down two radicand bits, try 4*root+1
  always_comb begin
    rem_sh = {rem[REM_W-3:0], rad[RAD_W-1 -: 2]};
    trial  = REM_W'({root, 2'b01});
    take   = (rem_sh >= trial);
  end

  // Control
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        busy <= 1'b1;
        cnt  <= ITER_W'(ROOT_W - 1);
      end else if (busy) begin
        if (cnt == '0) begin
          busy <= 1'b0;
          done <= 1'b1;
        end else begin
          cnt <= cnt - 1'b1;
        end
      end
    end
  end

  // Datapath
  always_ff @(posedge clk) begin
    if (req.start) begin
      rad  <= req.radicand;
      rem  <= '0;
      root <= '0;
    end else if (busy) begin
      rad <= {rad[RAD_W-3:0], 2'b00};
      if (take) begin
        rem  <= rem_sh - trial;
        root <= {root[ROOT_W-2:0], 1'b1};
      end else begin
        rem  <= rem_sh;
        root <= {root[ROOT_W-2:0], 1'b0};
      end
    end
  end

  assign rsp.done = done;
  assign rsp.root = root;

endmodule

// ===== sv/frame_difference_motion_detector.sv =====
// frame_difference_motion_detector: top level, sequencer, frame sum and report.
// Depends on fdmd_pkg, fdmd_ram (frame store) and fdmd_isqrt (root unit).
//
//  channel | dir | handshake             | beat contents
//  --------+-----+-----------------------+---------------------------------------
//  cfg     | in  | cfg_write_en          | cfg_write_data: motion threshold
//  in      | in  | in_valid / in_ready   | pixel_red/green/blue, frame_end
//  out     | out | out_valid / out_ready | motion, distance_total, pixels_in_frame
//
// A pixel of a frame with a stored predecessor goes from accept to the next
// in_ready through read, square, start, the root unit (one bit per cycle
// over 15 bits) and write back. Fill-frame pixels are only written back;
// pixels beyond the store are dropped and leave in_ready high. A frame end adds
// close, multiply and compare before in_ready returns; on the fill frame only close.
// Reset (rst, synchronous) clears control state and sets the threshold to 40;
// the store has no clearing pass. A result waits in the output register
// while later pixels are taken; only the next report stalls on it.
`timescale 1ns / 1ps

module frame_difference_motion_detector
  import fdmd_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              cfg_write_en,
  input  logic [THR_W-1:0]  cfg_write_data,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic [CH_W-1:0]   pixel_red,
  input  logic [CH_W-1:0]   pixel_green,
  input  logic [CH_W-1:0]   pixel_blue,
  input  logic              frame_end,
  output logic              out_valid,
  input  logic              out_ready,
  output logic              motion,
  output logic [SUM_W-1:0]  distance_total,
  output logic [CNT_W-1:0]  pixels_in_frame
);

  state_t state, state_next;

  logic [THR_W-1:0]  threshold;
  logic              have_prev;
  logic [SUM_W-1:0]  sum;
  logic [IDX_W-1:0]  idx;
  logic [PIX_W-1:0]  pix;
  logic              last;
  logic [SQ_W-1:0]   sq_r, sq_g, sq_b;
  logic [PROD_W-1:0] product;

  logic              accept;
  logic              in_range;
  logic              slot_free;
  logic [PIX_W-1:0]  old_pix;
  root_req_t         root_req;
  root_rsp_t         root_rsp;

  logic [CH_W-1:0]   d_r, d_g, d_b;
  logic [WD_W-1:0]   w_r, w_g, w_b;
  logic [SQ_SUM_W-1:0] sq_sum;
  logic [SUM_W:0]    sum_add;
  logic [CMP_W-1:0]  limit;

  assign in_ready  = (state == S_IDLE);
  assign accept    = in_valid && in_ready;
  assign in_range  = (idx < IDX_W'(MAX_PIXELS));
  assign slot_free = !out_valid || out_ready;

  // Threshold register
  always_ff @(posedge clk) begin
    if (rst) begin
      threshold <= THR_RESET;
    end else if (cfg_write_en) begin
      threshold <= cfg_write_data;
    end
  end

  // Frame store: read at accept, write back after the sum
  fdmd_ram #(
    .WIDTH (PIX_W),
    .DEPTH (MAX_PIXELS)
  ) u_store (
    .clk   (clk),
    .we    (state == S_ACC),
    .waddr (idx[ADDR_W-1:0]),
    .wdata (pix),
    .re    (accept && in_range && have_prev),
    .raddr (idx[ADDR_W-1:0]),
    .rdata (old_pix)
  );

  // Weighted channel differences against the stored pixel
  always_comb begin
    d_r = (pix[23:16] >= old_pix[23:16]) ? pix[23:16] - old_pix[23:16]
                                          : old_pix[23:16] - pix[23:16];
    d_g = (pix[15:8] >= old_pix[15:8]) ? pix[15:8] - old_pix[15:8]
                                        : old_pix[15:8] - pix[15:8];
    d_b = (pix[7:0] >= old_pix[7:0]) ? pix[7:0] - old_pix[7:0]
                                      : old_pix[7:0] - pix[7:0];
    w_r = {1'b0, d_r, 1'b0};
    w_g = {d_g, 2'b00};
    w_b = WD_W'(d_b) + {1'b0, d_b, 1'b0};
  end

  // Squares, registered before the sum
  always_ff @(posedge clk) begin
    if (state == S_DIFF) begin
      sq_r <= w_r * w_r;
      sq_g <= w_g * w_g;
      sq_b <= w_b * w_b;
    end
  end

  // Root of 256 * sum of squares gives the distance with 4 fraction bits
  assign sq_sum            = SQ_SUM_W'(sq_r) + SQ_SUM_W'(sq_g) + SQ_SUM_W'(sq_b);
  assign root_req.start    = (state == S_SUMSQ);
  assign root_req.radicand = RAD_W'({sq_sum, 8'h00});

  fdmd_isqrt u_isqrt (
    .clk (clk),
    .rst (rst),
    .req (root_req),
    .rsp (root_rsp)
  );

  // Saturating frame sum
  assign sum_add = {1'b0, sum} + (SUM_W + 1)'(root_rsp.root);
  assign limit   = CMP_W'({product, 4'b0000});

  // Sequencer
  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (accept) begin
          if (in_range) begin
            state_next = have_prev ? S_DIFF : S_ACC;
          end else if (frame_end) begin
            state_next = S_CLOSE;
          end
        end
      end
      S_DIFF:   state_next = S_SUMSQ;
      S_SUMSQ:  state_next = S_ROOT;
      S_ROOT: begin
        if (root_rsp.done) begin
          state_next = S_ACC;
        end
      end
      S_ACC:    state_next = last ? S_CLOSE : S_IDLE;
      S_CLOSE:  state_next = have_prev ? S_MUL : S_IDLE;
      S_MUL:    state_next = S_REPORT;
      S_REPORT: begin
        if (slot_free) begin
          state_next = S_IDLE;
        end
      end
      default:  state_next = S_IDLE;
    endcase
  end

  // Control state: sequencer, frame sum, pixel index
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      have_prev <= 1'b0;
      sum       <= '0;
      idx       <= '0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      // Result beat: raised by a report, dropped once taken
      if (state == S_REPORT && slot_free) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_ROOT: begin
          if (root_rsp.done) begin
            sum <= sum_add[SUM_W] ? SUM_MAX : sum_add[SUM_W-1:0];
          end
        end
        S_ACC: begin
          idx <= idx + 1'b1;
        end
        S_CLOSE: begin
          if (!have_prev) begin
            have_prev <= 1'b1;
            sum       <= '0;
            idx       <= '0;
          end
        end
        S_REPORT: begin
          if (slot_free) begin
            sum       <= '0;
            idx       <= '0;
          end
        end
        default: ;
      endcase
    end
  end

  // Input beat and threshold product
  always_ff @(posedge clk) begin
    if (accept) begin
      pix  <= {pixel_red, pixel_green, pixel_blue};
      last <= frame_end;
    end
    if (state == S_MUL) begin
      product <= threshold * idx;
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (state == S_REPORT && slot_free) begin
      motion          <= (CMP_W'(sum) >= limit);
      distance_total  <= sum;
      pixels_in_frame <= CNT_W'(idx);
    end
  end

endmodule

// ===== sv/fdmd_checker.sv =====
// fdmd_checker: port-level assertions for the motion detector, bound to the top.
// Depends on fdmd_pkg (field widths).
`timescale 1ns / 1ps

module fdmd_checker
  import fdmd_pkg::*;
(
  input logic             clk,
  input logic             rst,
  input logic             in_valid,
  input logic             in_ready,
  input logic             out_valid,
  input logic             out_ready,
  input logic             motion,
  input logic [SUM_W-1:0] distance_total,
  input logic [CNT_W-1:0] pixels_in_frame
);

  // A waiting result beat holds its payload
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(distance_total)
      && $stable(pixels_in_frame) && $stable(motion))
    else $error("result beat changed while stalled");

  // Nothing is reported straight out of reset
  a_reset_quiet: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("result beat right after reset");

  // A report always covers at least one pixel
  a_count_nonzero: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> pixels_in_frame != '0)
    else $error("report with empty frame");

  // Each pixel adds at most the largest distance
  a_sum_bound: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (34'(distance_total) <= 34'(pixels_in_frame) * 34'd21971))
    else $error("frame sum exceeds per-pixel bound");

  // A report never rises right after an input beat
  a_report_needs_input: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> !$past(in_valid && in_ready))
    else $error("report came too soon after an input beat");

endmodule

bind frame_difference_motion_detector fdmd_checker u_fdmd_checker (
  .clk             (clk),
  .rst             (rst),
  .in_valid        (in_valid),
  .in_ready        (in_ready),
  .out_valid       (out_valid),
  .out_ready       (out_ready),
  .motion          (motion),
  .distance_total  (distance_total),
  .pixels_in_frame (pixels_in_frame)
);
